// ===== rtl/lsc_pkg.sv =====
// ----------------------------------------------------------------------------
// lsc_pkg
// shared types and constants of the lru sector cache
// ----------------------------------------------------------------------------
package lsc_pkg;

	localparam int CACHE_LINES  = 64;
	localparam int SECTOR_WORDS = 64;
	localparam int LINE_W       = (CACHE_LINES > 1) ? $clog2(CACHE_LINES) : 1;
	localparam int WORD_W       = (SECTOR_WORDS > 1) ? $clog2(SECTOR_WORDS) : 1;
	localparam int RANK_W       = LINE_W;
	localparam int KEY_W        = 20;
	localparam int DADDR_W      = LINE_W + WORD_W;

	typedef enum logic {
		KIND_GET = 1'b0,
		KIND_PUT = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [9:0]  track;
		logic [9:0]  sector;
		logic [63:0] data_word;
		logic        last_in;
	} req_t;

	typedef struct packed {
		logic        hit;
		logic        evicted;
		logic [63:0] read_word;
		logic        last_out;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SCAN_END,
		ST_DECIDE,
		ST_UPD,
		ST_UPD_END,
		ST_GET_RD,
		ST_GET_LD
	} state_t;

endpackage

// ===== rtl/lru_sector_cache.sv =====
// ----------------------------------------------------------------------------
// lru_sector_cache
// fully associative lru cache of disk sectors with streamed put and get runs
// ----------------------------------------------------------------------------
// A put run is a series of beats, one data word each, the last one marked; a
// get is one beat. The first beat of a put, and every get, sweeps the tag and
// rank memories one line per cycle, and the line is chosen once the sweep has
// ended; a get miss loads its result then. A put or a get hit sweeps the rank
// memory once more to age the other lines, so the next beat is taken only
// after that second sweep. Further beats of an open put write the data memory
// directly, with no sweep, while the result register is empty. A get hit
// streams SECTOR_WORDS result beats; for each, the data memory is read once
// the result register is empty, and the registered read word is then loaded
// into it. A put status or get miss is a single result beat. A new beat is
// taken only once the block is idle and its result register has been
// drained.
module lru_sector_cache (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  lsc_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output lsc_pkg::rsp_t rsp
);
	import lsc_pkg::*;

	state_t state_q, state_d;

	logic [KEY_W-1:0]   tag_mem [CACHE_LINES];
	logic [RANK_W-1:0]  rank_mem [CACHE_LINES];
	logic [63:0]        data_mem [CACHE_LINES*SECTOR_WORDS];
	logic [KEY_W-1:0]   tag_rd_s1;
	logic [RANK_W-1:0]  rank_rd_s1;
	logic [63:0]        data_rd_s1;

	logic [CACHE_LINES-1:0] line_valid_q;

	req_t               item_q;
	logic [KEY_W-1:0]   key;
	logic [LINE_W-1:0]  idx_q;
	logic               scan_v_s1;
	logic               upd_v_s1;
	logic [LINE_W-1:0]  scan_idx_s1;
	logic               hit_found_q, free_found_q;
	logic [LINE_W-1:0]  hit_idx_q, free_idx_q, max_idx_q;
	logic [RANK_W-1:0]  max_rank_q, hit_rank_q;
	logic [LINE_W:0]    cnt_q;

	logic [LINE_W-1:0]  put_slot_q;
	logic [WORD_W:0]    put_cnt_q;
	logic               put_active_q, put_was_hit_q, put_evicted_q;
	logic [LINE_W-1:0]  get_slot_q;
	logic [WORD_W-1:0]  word_q;

	logic               out_valid_q;
	rsp_t               out_q;

	logic               accept, cont_put;
	logic [LINE_W-1:0]  sel;
	logic [RANK_W-1:0]  old_rank;
	logic               full;

	assign accept    = req_valid && !req_stall;
	assign cont_put  = accept && req.kind == KIND_PUT && put_active_q;
	assign key       = {item_q.track, item_q.sector};
	assign full      = !free_found_q;
	assign req_stall = (state_q != ST_IDLE) || out_valid_q;
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	always_comb begin
		if (hit_found_q) begin
			sel = hit_idx_q;
		end else if (free_found_q) begin
			sel = free_idx_q;
		end else begin
			sel = max_idx_q;
		end
		if (hit_found_q) begin
			old_rank = hit_rank_q;
		end else if (full) begin
			old_rank = max_rank_q;
		end else begin
			old_rank = cnt_q[RANK_W-1:0];
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && !cont_put) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (idx_q == LINE_W'(CACHE_LINES-1)) begin
					state_d = ST_SCAN_END;
				end
			end
			ST_SCAN_END: state_d = ST_DECIDE;
			ST_DECIDE: begin
				if (item_q.kind == KIND_PUT || hit_found_q) begin
					state_d = ST_UPD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_UPD: begin
				if (idx_q == LINE_W'(CACHE_LINES-1)) begin
					state_d = ST_UPD_END;
				end
			end
			ST_UPD_END: begin
				if (item_q.kind == KIND_GET) begin
					state_d = ST_GET_RD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_GET_RD: begin
				if (!out_valid_q) begin
					state_d = ST_GET_LD;
				end
			end
			ST_GET_LD: begin
				if (word_q == WORD_W'(SECTOR_WORDS-1)) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_GET_RD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// tag memory
	always_ff @(posedge clk) begin
		if (state_q == ST_DECIDE && item_q.kind == KIND_PUT && !hit_found_q) begin
			tag_mem[sel] <= key;
		end
		tag_rd_s1 <= tag_mem[idx_q];
	end

	// rank memory, aged one line per cycle after a line is claimed
	always_ff @(posedge clk) begin
		if (upd_v_s1) begin
			if (scan_idx_s1 == sel) begin
				rank_mem[scan_idx_s1] <= '0;
			end else if (line_valid_q[scan_idx_s1] && rank_rd_s1 < old_rank) begin
				rank_mem[scan_idx_s1] <= rank_rd_s1 + RANK_W'(1);
			end
		end
		rank_rd_s1 <= rank_mem[idx_q];
	end

	// data memory
	always_ff @(posedge clk) begin
		if (cont_put && put_cnt_q < (WORD_W+1)'(SECTOR_WORDS)) begin
			data_mem[{put_slot_q, put_cnt_q[WORD_W-1:0]}] <= req.data_word;
		end else if (state_q == ST_DECIDE && item_q.kind == KIND_PUT) begin
			data_mem[{sel, WORD_W'(0)}] <= item_q.data_word;
		end
		data_rd_s1 <= data_mem[{get_slot_q, word_q}];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			scan_v_s1    <= 1'b0;
			upd_v_s1     <= 1'b0;
			scan_idx_s1  <= '0;
			hit_found_q  <= 1'b0;
			free_found_q <= 1'b0;
			hit_idx_q    <= '0;
			hit_rank_q   <= '0;
			free_idx_q   <= '0;
			max_idx_q    <= '0;
			max_rank_q   <= '0;
			cnt_q        <= '0;
		end else begin
			scan_v_s1   <= (state_q == ST_SCAN);
			upd_v_s1    <= (state_q == ST_UPD);
			scan_idx_s1 <= idx_q;
			if (state_q == ST_SCAN || state_q == ST_UPD) begin
				idx_q <= idx_q + LINE_W'(1);
			end
			if (state_q == ST_DECIDE) begin
				idx_q <= '0;
			end
			if (accept && !cont_put) begin
				idx_q        <= '0;
				hit_found_q  <= 1'b0;
				free_found_q <= 1'b0;
				max_idx_q    <= '0;
				max_rank_q   <= '0;
				cnt_q        <= '0;
			end else if (scan_v_s1) begin
				if (line_valid_q[scan_idx_s1]) begin
					cnt_q <= cnt_q + (LINE_W+1)'(1);
					if (tag_rd_s1 == key && !hit_found_q) begin
						hit_found_q <= 1'b1;
						hit_idx_q   <= scan_idx_s1;
						hit_rank_q  <= rank_rd_s1;
					end
					if (rank_rd_s1 > max_rank_q) begin
						max_rank_q <= rank_rd_s1;
						max_idx_q  <= scan_idx_s1;
					end
				end else if (!free_found_q) begin
					free_found_q <= 1'b1;
					free_idx_q   <= scan_idx_s1;
				end
			end
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_valid_q <= '0;
		end else if (state_q == ST_DECIDE && (item_q.kind == KIND_PUT || hit_found_q)) begin
			line_valid_q[sel] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			put_slot_q    <= '0;
			put_cnt_q     <= '0;
			put_active_q  <= 1'b0;
			put_was_hit_q <= 1'b0;
			put_evicted_q <= 1'b0;
			get_slot_q    <= '0;
			word_q        <= '0;
			out_valid_q   <= 1'b0;
			out_q         <= '0;
		end else begin
			if (out_valid_q && !rsp_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cont_put) begin
				if (put_cnt_q < (WORD_W+1)'(SECTOR_WORDS)) begin
					put_cnt_q <= put_cnt_q + (WORD_W+1)'(1);
				end
				if (req.last_in) begin
					put_active_q <= 1'b0;
					out_valid_q  <= 1'b1;
					out_q        <= '{hit: put_was_hit_q, evicted: put_evicted_q,
						read_word: 64'd0, last_out: 1'b1};
				end
			end else if (accept && req.kind == KIND_GET) begin
				put_active_q <= 1'b0;
			end
			if (state_q == ST_DECIDE) begin
				if (item_q.kind == KIND_PUT) begin
					put_slot_q    <= sel;
					put_cnt_q     <= (WORD_W+1)'(1);
					put_active_q  <= !item_q.last_in;
					put_was_hit_q <= hit_found_q;
					put_evicted_q <= !hit_found_q && full;
					if (item_q.last_in) begin
						out_valid_q <= 1'b1;
						out_q       <= '{hit: hit_found_q, evicted: !hit_found_q && full,
							read_word: 64'd0, last_out: 1'b1};
					end
				end else if (hit_found_q) begin
					get_slot_q <= sel;
					word_q     <= '0;
				end else begin
					out_valid_q <= 1'b1;
					out_q       <= '{hit: 1'b0, evicted: 1'b0, read_word: 64'd0,
						last_out: 1'b1};
				end
			end
			if (state_q == ST_GET_LD) begin
				out_valid_q <= 1'b1;
				out_q       <= '{hit: 1'b1, evicted: 1'b0, read_word: data_rd_s1,
					last_out: word_q == WORD_W'(SECTOR_WORDS-1)};
				word_q      <= word_q + WORD_W'(1);
			end
		end
	end

	// a result is never loaded over one still waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_GET_LD |-> $past(!out_valid_q))
		else $error("result register overwritten");

	// a hit always points at a valid line
	assert property (@(posedge clk) disable iff (!arst_n)
		hit_found_q |-> line_valid_q[hit_idx_q])
		else $error("hit on invalid line");

	// put word count never passes the sector size
	assert property (@(posedge clk) disable iff (!arst_n)
		put_cnt_q <= (WORD_W+1)'(SECTOR_WORDS))
		else $error("put word count overflow");

	// the scan pipeline is drained when the line is chosen
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DECIDE |-> !scan_v_s1)
		else $error("decision before scan end");

endmodule

// ===== tb/sv/tb_lru_sector_cache.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_sector_cache
// self-checking testbench of the lru sector cache
// ----------------------------------------------------------------------------
// Put runs and gets go in through the request channel. A cycle-free model of
// the cache (tags, lru ranks, sector data, open put) predicts every response
// beat, and each accepted response is compared field by field with the oldest
// prediction. Directed runs cover extreme keys and data, hits, misses, short,
// overlong and abandoned puts, then a fill past capacity forces evictions, and
// a random mix follows. Both sides idle at random; a long response hold-off
// backs the block up.
// ----------------------------------------------------------------------------
module tb_lru_sector_cache;
	import lsc_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	bit quiet = 1'b0;
	int hold_cnt = 0;
	int errors = 0;
	int beats_in = 0;
	int beats_out = 0;
	int evictions = 0;
	int get_hits = 0;
	int abandoned = 0;

	rsp_t expected_rsp_q[$];

	logic [KEY_W-1:0] ln_tag[CACHE_LINES];
	bit ln_valid[CACHE_LINES];
	int ln_rank[CACHE_LINES];
	logic [63:0] ln_data[CACHE_LINES*SECTOR_WORDS];
	bit ln_written[CACHE_LINES*SECTOR_WORDS];
	int put_line;
	int put_words;
	bit put_open;
	bit put_hit;
	bit put_evict;

	logic [KEY_W-1:0] key_pool[8];

	lru_sector_cache dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always #6 clk = ~clk;

	function automatic int find_line(logic [KEY_W-1:0] key);
		for (int i = 0; i < CACHE_LINES; i++)
			if (ln_valid[i] && ln_tag[i] == key)
				return i;
		return -1;
	endfunction

	function automatic bit line_full(int s);
		for (int i = 0; i < SECTOR_WORDS; i++)
			if (!ln_written[s*SECTOR_WORDS+i])
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic void touch_line(int s, int old_rank);
		for (int i = 0; i < CACHE_LINES; i++)
			if (i != s && ln_valid[i] && ln_rank[i] < old_rank)
				ln_rank[i]++;
		ln_rank[s] = 0;
		ln_valid[s] = 1'b1;
	endfunction

	function automatic void push_rsp(bit h, bit e, logic [63:0] w, bit l);
		rsp_t x;
		x.hit = h;
		x.evicted = e;
		x.read_word = w;
		x.last_out = l;
		expected_rsp_q.push_back(x);
	endfunction

	function automatic void predict_cache(req_t r);
		logic [KEY_W-1:0] key;
		int s;
		int n;
		key = {r.track, r.sector};
		if (r.kind == KIND_PUT) begin
			if (!put_open) begin
				s = find_line(key);
				put_evict = 1'b0;
				if (s >= 0) begin
					put_hit = 1'b1;
					touch_line(s, ln_rank[s]);
				end else begin
					put_hit = 1'b0;
					n = 0;
					for (int i = 0; i < CACHE_LINES; i++)
						if (ln_valid[i])
							n++;
					if (n < CACHE_LINES) begin
						s = 0;
						for (int i = CACHE_LINES - 1; i >= 0; i--)
							if (!ln_valid[i])
								s = i;
						touch_line(s, n);
					end else begin
						s = 0;
						for (int i = 1; i < CACHE_LINES; i++)
							if (ln_rank[i] > ln_rank[s])
								s = i;
						put_evict = 1'b1;
						evictions++;
						touch_line(s, ln_rank[s]);
					end
					ln_tag[s] = key;
				end
				put_line = s;
				put_words = 0;
				put_open = 1'b1;
			end
			if (put_words < SECTOR_WORDS) begin
				ln_data[put_line*SECTOR_WORDS+put_words] = r.data_word;
				ln_written[put_line*SECTOR_WORDS+put_words] = 1'b1;
				put_words++;
			end
			if (r.last_in) begin
				put_open = 1'b0;
				push_rsp(put_hit, put_evict, '0, 1'b1);
			end
		end else begin
			if (put_open)
				abandoned++;
			put_open = 1'b0;
			s = find_line(key);
			if (s < 0) begin
				push_rsp(1'b0, 1'b0, '0, 1'b1);
			end else begin
				get_hits++;
				touch_line(s, ln_rank[s]);
				for (int i = 0; i < SECTOR_WORDS; i++)
					push_rsp(1'b1, 1'b0, ln_data[s*SECTOR_WORDS+i], i == SECTOR_WORDS - 1);
			end
		end
	endfunction

	task automatic send_beat(req_t r);
		bit taken;
		if (!quiet && $urandom_range(99) < 15) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		forever begin
			@(negedge clk);
			taken = !req_stall;
			@(posedge clk);
			if (taken)
				break;
		end
		beats_in++;
		predict_cache(r);
	endtask

	function automatic logic [63:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [KEY_W-1:0] rand_key();
		return {10'($urandom_range(1023)), 10'($urandom_range(1023))};
	endfunction

	task automatic put_run(logic [KEY_W-1:0] key, int nwords, bit close);
		req_t r;
		for (int i = 0; i < nwords; i++) begin
			r.kind = KIND_PUT;
			r.track = key[19:10];
			r.sector = key[9:0];
			case ($urandom_range(15))
				0: r.data_word = '0;
				1: r.data_word = '1;
				default: r.data_word = rand_word();
			endcase
			r.last_in = close && (i == nwords - 1);
			send_beat(r);
		end
	endtask

	task automatic get_sector(logic [KEY_W-1:0] key);
		req_t r;
		r.kind = KIND_GET;
		r.track = key[19:10];
		r.sector = key[9:0];
		r.data_word = rand_word();
		r.last_in = 1'($urandom_range(1));
		send_beat(r);
	endtask

	// a hit on a line with unwritten words is never read back
	task automatic safe_get(logic [KEY_W-1:0] key);
		logic [KEY_W-1:0] k;
		int s;
		k = key;
		s = find_line(k);
		while (s >= 0 && !line_full(s)) begin
			k = rand_key();
			s = find_line(k);
		end
		get_sector(k);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (expected_rsp_q.size() > 0)
			@(posedge clk);
	endtask

	task automatic test_directed();
		get_sector(20'h00000);
		put_run(20'hFFFFF, SECTOR_WORDS + 2, 1'b1);
		get_sector(20'hFFFFF);
		put_run(20'hFFFFF, 3, 1'b1);
		get_sector(20'hFFFFF);
		// open put cut short by a get
		put_run(20'hFFFFF, 2, 1'b0);
		get_sector(20'h01C07);
		get_sector(20'hFFFFF);
		drain();
	endtask

	task automatic test_fill_evict();
		for (int i = 0; i < CACHE_LINES + 2; i++)
			put_run(rand_key(), 1, 1'b1);
		safe_get(20'hFFFFF);
		drain();
	endtask

	task automatic test_random(int count);
		logic [KEY_W-1:0] key;
		int len;
		int start;
		start = beats_in;
		while (beats_in - start < count) begin
			quiet = (beats_in - start) > count / 2 && (beats_in - start) < count * 3 / 4;
			key = $urandom_range(3) != 0 ? key_pool[$urandom_range(7)] : rand_key();
			if ($urandom_range(9) < 6) begin
				len = $urandom_range(1, 6);
				if ($urandom_range(9) < 2) begin
					put_run(key, len, 1'b0);
					safe_get(key);
				end else begin
					put_run(key, len, 1'b1);
				end
			end else begin
				safe_get(key);
			end
		end
		quiet = 1'b0;
		drain();
	endtask

	task automatic test_backpressure();
		hold_cnt <= 400;
		get_sector(20'hFFFFF);
		get_sector(20'h3FF00);
		put_run(20'h00000, 2, 1'b1);
		get_sector(20'hFFFFF);
		drain();
	endtask

	always @(posedge clk) begin
		if (hold_cnt > 0) begin
			rsp_stall <= 1'b1;
			hold_cnt <= hold_cnt - 1;
		end else begin
			rsp_stall <= !quiet && ($urandom_range(99) < 15);
		end
	end

	always @(negedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			beats_out++;
			if (expected_rsp_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected response beat: %p", rsp);
			end else begin
				want = expected_rsp_q.pop_front();
				if (rsp.hit !== want.hit || rsp.evicted !== want.evicted
						|| rsp.read_word !== want.read_word
						|| rsp.last_out !== want.last_out) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: exp hit=%0b ev=%0b word=%h last=%0b,",
							want.hit, want.evicted, want.read_word, want.last_out,
							" got hit=%0b ev=%0b word=%h last=%0b",
							rsp.hit, rsp.evicted, rsp.read_word, rsp.last_out);
				end
			end
		end
	end

	initial begin
		#12000000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		for (int i = 0; i < CACHE_LINES; i++) begin
			ln_valid[i] = 1'b0;
			ln_rank[i] = 0;
			ln_tag[i] = '0;
		end
		for (int i = 0; i < CACHE_LINES * SECTOR_WORDS; i++)
			ln_written[i] = 1'b0;
		put_open = 1'b0;
		put_line = 0;
		put_words = 0;
		put_hit = 1'b0;
		put_evict = 1'b0;
		key_pool[0] = 20'h00000;
		key_pool[1] = 20'hFFFFF;
		key_pool[2] = 20'h003FF;
		key_pool[3] = 20'hFFC00;
		for (int i = 4; i < 8; i++)
			key_pool[i] = rand_key();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_fill_evict();
		test_random(24);
		drain();
		repeat (300) @(posedge clk);
		if (expected_rsp_q.size() != 0)
			errors++;
		$display("covered %0d request beats, %0d response beats, %0d get hits",
			beats_in, beats_out, get_hits);
		$display("with %0d evictions, %0d cut-short puts and a long response hold-off",
			evictions, abandoned);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
